// ===== design/mosel_pkg.sv =====
// shared types, codes and helpers for the motor output selector with tone
package mosel_pkg;

    localparam int unsigned DIV_W = 15;
    localparam int unsigned DSR_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LOOP_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_CURRENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_CURRENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARKING_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_THRESHOLD = 3'd4;

    localparam logic signed [20:0] CUR_LIMIT = 21'sd200000;
    localparam logic signed [20:0] CUR_LIMIT_NEG = -21'sd200000;
    localparam logic [17:0] PARK_SLOW_ERPM = 18'd50;
    localparam logic [17:0] PARK_HOLD_ERPM = 18'd2000;
    localparam logic [DSR_W-1:0] CLICK_FREQ_HZ = 16'd350;
    localparam logic [1:0] CLICK_HALVES = 2'd3;
    localparam logic [31:0] RELEASE_MS = 32'd1000;
    localparam logic [7:0] TONE_PERIOD_MAX = 8'd255;
    localparam logic [7:0] TONE_PERIOD_MIN = 8'd1;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_CLICK = 2'd3
    } tone_cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_DUTY0 = 2'd2,
        ACT_BRAKE = 2'd3
    } action_t;

    localparam logic [1:0] RS_DISABLED = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;

    localparam logic [1:0] PARK_NEVER = 2'd0;
    localparam logic [1:0] PARK_IDLE_SLOW = 2'd1;
    localparam logic [1:0] PARK_ALWAYS = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } mosel_cmd_t;

    typedef struct packed {
        logic div_done;
    } mosel_status_t;

    function automatic logic signed [18:0] sat_cur(input logic signed [20:0] v);
        logic signed [18:0] r;
        if (v > CUR_LIMIT)
            r = CUR_LIMIT[18:0];
        else if (v < CUR_LIMIT_NEG)
            r = CUR_LIMIT_NEG[18:0];
        else
            r = v[18:0];
        return r;
    endfunction

    function automatic logic [7:0] clamp_period(input logic [DIV_W-1:0] quo,
                                               input logic freq_zero);
        logic [7:0] r;
        if (freq_zero)
            r = TONE_PERIOD_MAX;
        else if (quo == '0)
            r = TONE_PERIOD_MIN;
        else if (quo > DIV_W'(TONE_PERIOD_MAX))
            r = TONE_PERIOD_MAX;
        else
            r = quo[7:0];
        return r;
    endfunction

endpackage

// ===== design/mosel_div.sv =====
// bit-serial restoring divider for the tone period
module mosel_div
    import mosel_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge = trial >= {1'b0, dsr_reg};
    assign diff = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done = done_reg;

endmodule

// ===== design/mosel_dp.sv =====
// datapath: configuration, tone generator, request latch and command selection
module mosel_dp
    import mosel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mosel_cmd_t            ctl,
    output mosel_status_t         status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            cmd,
    input  logic [15:0]           tone_freq_hz,
    input  logic [16:0]           tone_level_ma,
    input  logic                  request_valid,
    input  logic signed [18:0]    request_ma,
    input  logic [17:0]           speed_erpm,
    input  logic [1:0]            run_state,
    input  logic [31:0]           now_ms,
    output logic [1:0]            action,
    output logic signed [18:0]    drive_ma,
    output logic                  off_delay,
    output logic                  watchdog_kick
);

    // configuration
    logic [14:0] half_loop_freq_reg;
    logic [16:0] brake_current_reg;
    logic [16:0] click_current_reg;
    logic [1:0]  parking_mode_reg;
    logic [17:0] moving_threshold_reg;

    // captured beat
    tone_cmd_t          cmd_reg;
    logic [15:0]        freq_reg;
    logic [16:0]        level_reg;
    logic               rq_reg;
    logic signed [18:0] rq_ma_reg;
    logic [17:0]        speed_reg;
    logic [1:0]         rs_reg;
    logic [31:0]        now_reg;

    // block state
    logic               off_latched_reg;
    logic               req_pending_reg;
    logic signed [18:0] req_value_reg;
    logic               park_active_reg;
    logic [31:0]        last_move_reg;
    logic [7:0]         tone_period_reg;
    logic [7:0]         tone_count_reg;
    logic               tone_phase_reg;
    logic [16:0]        tone_amp_reg;
    logic [1:0]         clicks_left_reg;

    // result
    action_t            action_reg;
    logic signed [18:0] drive_reg;
    logic               off_delay_reg;
    logic               kick_reg;

    logic               off_latched_next;
    logic               req_pending_next;
    logic signed [18:0] req_value_next;
    logic               park_active_next;
    logic [31:0]        last_move_next;
    logic [7:0]         tone_period_next;
    logic [7:0]         tone_count_next;
    logic               tone_phase_next;
    logic [16:0]        tone_amp_next;
    logic [1:0]         clicks_left_next;
    action_t            action_next;
    logic signed [18:0] drive_next;
    logic               off_delay_next;
    logic               kick_next;

    logic [DIV_W-1:0]   quotient;
    logic [DSR_W-1:0]   divisor;
    logic [7:0]         period_q;

    assign divisor = (tone_cmd_t'(cmd) == CMD_CLICK) ? CLICK_FREQ_HZ : tone_freq_hz;

    mosel_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.capture),
        .dividend (half_loop_freq_reg),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (status.div_done)
    );

    assign period_q = clamp_period(quotient, (cmd_reg == CMD_PLAY) && (freq_reg == '0));

    always_comb
    begin
        logic               running;
        logic [7:0]         cnt_dec;
        logic signed [20:0] val_w;
        logic signed [20:0] amp_w;
        logic [31:0]        elapsed;

        running = (rs_reg == RS_RUNNING);
        off_latched_next = off_latched_reg;
        req_pending_next = req_pending_reg;
        req_value_next = req_value_reg;
        park_active_next = park_active_reg;
        last_move_next = last_move_reg;
        tone_period_next = tone_period_reg;
        tone_count_next = tone_count_reg;
        tone_phase_next = tone_phase_reg;
        tone_amp_next = tone_amp_reg;
        clicks_left_next = clicks_left_reg;
        action_next = ACT_NONE;
        drive_next = '0;
        off_delay_next = 1'b0;
        kick_next = 1'b0;
        cnt_dec = '0;
        val_w = '0;
        amp_w = '0;
        elapsed = '0;

        if (rq_reg)
        begin
            req_pending_next = 1'b1;
            req_value_next = sat_cur(21'(rq_ma_reg));
        end

        unique case (cmd_reg)
            CMD_PLAY:
            begin
                if (period_q != tone_period_next)
                begin
                    tone_period_next = period_q;
                    tone_count_next = period_q;
                end
                tone_amp_next = level_reg;
            end
            CMD_STOP:
            begin
                tone_period_next = '0;
                tone_count_next = '0;
                tone_phase_next = 1'b0;
            end
            CMD_CLICK:
            begin
                if (click_current_reg != '0)
                begin
                    if (period_q != tone_period_next)
                    begin
                        tone_period_next = period_q;
                        tone_count_next = period_q;
                    end
                    tone_amp_next = click_current_reg;
                    clicks_left_next = CLICK_HALVES;
                end
            end
            CMD_NONE:
            begin
            end
        endcase

        if (rs_reg == RS_DISABLED)
        begin
            action_next = off_latched_reg ? ACT_NONE : ACT_SET;
            off_latched_next = 1'b1;
        end
        else
        begin
            off_latched_next = 1'b0;

            if (parking_mode_reg == PARK_ALWAYS ||
                (parking_mode_reg == PARK_IDLE_SLOW && !running &&
                 speed_reg < PARK_SLOW_ERPM))
                park_active_next = 1'b1;
            else if (parking_mode_reg == PARK_NEVER || running)
                park_active_next = 1'b0;

            if (tone_period_next != '0)
            begin
                req_pending_next = 1'b1;
                cnt_dec = tone_count_next - 1'b1;
                tone_count_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    tone_count_next = tone_period_next;
                    tone_phase_next = !tone_phase_next;
                    if (clicks_left_next != '0)
                    begin
                        clicks_left_next = clicks_left_next - 1'b1;
                        if (clicks_left_next == '0)
                        begin
                            tone_period_next = '0;
                            tone_count_next = '0;
                            tone_phase_next = 1'b0;
                        end
                    end
                end
                val_w = 21'(req_value_next);
                amp_w = $signed({4'b0000, tone_amp_next});
                req_value_next = sat_cur(tone_phase_next ? val_w + amp_w : val_w - amp_w);
            end

            kick_next = 1'b1;
            if (req_pending_next)
            begin
                action_next = ACT_SET;
                drive_next = req_value_next;
                off_delay_next = 1'b1;
            end
            else
            begin
                if (speed_reg > moving_threshold_reg)
                    last_move_next = now_reg;
                elapsed = now_reg - last_move_next;
                if (elapsed > RELEASE_MS)
                    action_next = ACT_SET;
                else if (park_active_next && speed_reg < PARK_HOLD_ERPM)
                    action_next = ACT_DUTY0;
                else
                begin
                    action_next = ACT_BRAKE;
                    drive_next = $signed({2'b00, brake_current_reg});
                end
            end
            req_pending_next = 1'b0;
            req_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_loop_freq_reg <= 15'd400;
            brake_current_reg <= 17'd5000;
            click_current_reg <= '0;
            parking_mode_reg <= PARK_NEVER;
            moving_threshold_reg <= 18'd1000;
            off_latched_reg <= 1'b0;
            req_pending_reg <= 1'b0;
            req_value_reg <= '0;
            park_active_reg <= 1'b0;
            last_move_reg <= '0;
            tone_period_reg <= '0;
            tone_count_reg <= '0;
            tone_phase_reg <= 1'b0;
            tone_amp_reg <= '0;
            clicks_left_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HALF_LOOP_FREQ:   half_loop_freq_reg <= cfg_data[14:0];
                    CFG_BRAKE_CURRENT:    brake_current_reg <= cfg_data[16:0];
                    CFG_CLICK_CURRENT:    click_current_reg <= cfg_data[16:0];
                    CFG_PARKING_MODE:     parking_mode_reg <= cfg_data[1:0];
                    CFG_MOVING_THRESHOLD: moving_threshold_reg <= cfg_data[17:0];
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.commit)
            begin
                off_latched_reg <= off_latched_next;
                req_pending_reg <= req_pending_next;
                req_value_reg <= req_value_next;
                park_active_reg <= park_active_next;
                last_move_reg <= last_move_next;
                tone_period_reg <= tone_period_next;
                tone_count_reg <= tone_count_next;
                tone_phase_reg <= tone_phase_next;
                tone_amp_reg <= tone_amp_next;
                clicks_left_reg <= clicks_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= tone_cmd_t'(cmd);
            freq_reg <= tone_freq_hz;
            level_reg <= tone_level_ma;
            rq_reg <= request_valid;
            rq_ma_reg <= request_ma;
            speed_reg <= speed_erpm;
            rs_reg <= run_state;
            now_reg <= now_ms;
        end
        if (ctl.commit)
        begin
            action_reg <= action_next;
            drive_reg <= drive_next;
            off_delay_reg <= off_delay_next;
            kick_reg <= kick_next;
        end
    end

    assign action = action_reg;
    assign drive_ma = drive_reg;
    assign off_delay = off_delay_reg;
    assign watchdog_kick = kick_reg;

`ifndef ASSERT_OFF
    a_tone_count_tracks_period: assert property (@(posedge clk) disable iff (!rst_n)
        (tone_period_reg == '0) == (tone_count_reg == '0))
        else $error("tone count and period disagree on idle");

    a_req_value_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !req_pending_reg |-> (req_value_reg == '0))
        else $error("stale request value without pending request");
`endif

endmodule

// ===== design/mosel_ctrl.sv =====
// controller: beat sequencing and output holding register
module mosel_ctrl
    import mosel_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  mosel_status_t status,
    output mosel_cmd_t    ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign ctl.capture = (state_reg == ST_IDLE) && in_valid;
    assign ctl.commit = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctl.capture)
                        state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (status.div_done)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (ctl.commit)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_capture_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> (state_reg == ST_DIVIDE))
        else $error("accepted beat did not start the divide");

    a_done_moves_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && status.div_done) |=> (state_reg == ST_EXEC))
        else $error("divider finish missed");

    a_done_only_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("committed result not presented");
`endif

endmodule

// ===== design/motor_output_selector_with_tone_unit.sv =====
// top level of the motor output selector with tone generator
//
// one input beat per control-loop tick gives exactly one output beat, the
// motor command for that tick. both channels use valid/stall; a beat moves
// on a rising edge with valid high and stall low.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written only while no tick is in flight.
// an accepted tick enters a 15-step bit-serial divider (tone period); its
// registered done flag hands the quotient over to the select stage, which
// selects the command and loads the output register once that register is
// free. the divider makes one quotient bit a cycle; a new tick waits until
// the previous one has committed.
// in_stall is low only while the controller is idle; a new tick may be
// taken while the previous result still waits in the output register.
// if the receiver stalls, the output beat holds and the next tick stops
// before its commit until the output register frees.
// reset clears the controller, the tone generator and the request latch,
// and loads the configuration defaults.
module motor_output_selector_with_tone_unit
    import mosel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [15:0]           tone_freq_hz,
    input  logic [16:0]           tone_level_ma,
    input  logic                  request_valid,
    input  logic signed [18:0]    request_ma,
    input  logic [17:0]           speed_erpm,
    input  logic [1:0]            run_state,
    input  logic [31:0]           now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            action,
    output logic signed [18:0]    drive_ma,
    output logic                  off_delay,
    output logic                  watchdog_kick
);

    mosel_cmd_t    ctl;
    mosel_status_t status;

    mosel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctl       (ctl)
    );

    mosel_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .tone_freq_hz  (tone_freq_hz),
        .tone_level_ma (tone_level_ma),
        .request_valid (request_valid),
        .request_ma    (request_ma),
        .speed_erpm    (speed_erpm),
        .run_state     (run_state),
        .now_ms        (now_ms),
        .action        (action),
        .drive_ma      (drive_ma),
        .off_delay     (off_delay),
        .watchdog_kick (watchdog_kick)
    );

endmodule
